FILE: rtl/pwm16_pkg.sv
// Shared constants and types for the sixteen-channel PWM register block.
`timescale 1ns / 1ps

package pwm16_pkg;

  localparam int CHANNELS      = 16;
  localparam int COUNT_BITS    = 12;
  localparam int LINE_BITS     = 16;
  localparam int CMP_BITS      = (COUNT_BITS > 12) ? COUNT_BITS : 12;
  localparam int CHAN_IDX_BITS = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  typedef logic [1:0] cmd_t;
  localparam cmd_t CMD_WRITE = 2'd0;
  localparam cmd_t CMD_READ  = 2'd1;
  localparam cmd_t CMD_TICK  = 2'd2;

  localparam logic [7:0] MODE_ADDR     = 8'h00;
  localparam logic [7:0] CHAN_BASE     = 8'h06;
  localparam logic [7:0] CHAN_LIMIT    = 8'(6 + 4 * CHANNELS);
  localparam logic [7:0] ALL_BASE      = 8'hFA;
  localparam logic [7:0] ALL_LAST      = 8'hFD;
  localparam logic [7:0] PRESCALE_ADDR = 8'hFE;

  localparam int SLEEP_BIT   = 4;
  localparam int RESTART_BIT = 7;
  localparam int FULL_BIT    = 4;

  localparam logic [7:0] PRESCALE_MIN   = 8'd3;
  localparam logic [7:0] MODE_RESET     = 8'h11;
  localparam logic [7:0] PRESCALE_RESET = 8'd30;

  // Byte order within a channel: ON low, ON high, OFF low, OFF high.
  localparam int ON_L  = 0;
  localparam int ON_H  = 1;
  localparam int OFF_L = 2;
  localparam int OFF_H = 3;

  typedef logic [3:0][7:0] chan_bytes_t;

  typedef struct packed {
    logic [3:0] we;
    logic [7:0] wdata;
  } chan_wr_t;

endpackage

FILE: rtl/pwm16_channel.sv
// One PWM channel: its four register bytes and the output compare rule.
`timescale 1ns / 1ps

module pwm16_channel (
  input  logic                             clk,
  input  logic                             rst,
  input  pwm16_pkg::chan_wr_t              wr,
  input  logic [pwm16_pkg::COUNT_BITS-1:0] count_next,
  output pwm16_pkg::chan_bytes_t           regs,
  output logic                             level_next
);
  import pwm16_pkg::*;

  chan_bytes_t         regs_next;
  logic [CMP_BITS-1:0] on_cnt;
  logic [CMP_BITS-1:0] off_cnt;
  logic [CMP_BITS-1:0] cnt;

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      regs_next[i] = wr.we[i] ? wr.wdata : regs[i];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      regs <= '0;
    end else begin
      regs <= regs_next;
    end
  end

  assign on_cnt  = CMP_BITS'({regs_next[ON_H][3:0], regs_next[ON_L]});
  assign off_cnt = CMP_BITS'({regs_next[OFF_H][3:0], regs_next[OFF_L]});
  assign cnt     = CMP_BITS'(count_next);

  // Full-off wins over full-on; an ON count above OFF wraps round the period.
  always_comb begin
    if (regs_next[OFF_H][FULL_BIT]) begin
      level_next = 1'b0;
    end else if (regs_next[ON_H][FULL_BIT]) begin
      level_next = 1'b1;
    end else if (on_cnt < off_cnt) begin
      level_next = (cnt >= on_cnt) && (cnt < off_cnt);
    end else if (on_cnt > off_cnt) begin
      level_next = (cnt >= on_cnt) || (cnt < off_cnt);
    end else begin
      level_next = 1'b0;
    end
  end

endmodule

FILE: rtl/sixteen_channel_pwm_register_block_unit.sv
// Top level of the sixteen-channel 12-bit PWM register block.
// Each word on the input channel is a register write, a register read or one
// oscillator tick, and each produces exactly one result word carrying the read
// data (zero unless a read) and the level of every channel after the word took
// effect. A word is taken into an input register and, from there, applied to the
// register file, prescale divider and counter while the result is captured in an
// output register; one word is accepted every cycle while the output is not stalled,
// and its result passes through the input register and then the output register.
// Reset leaves the device asleep with a prescale of 30.
`timescale 1ns / 1ps

module sixteen_channel_pwm_register_block_unit (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  pwm16_pkg::cmd_t                 cmd,
  input  logic [7:0]                      reg_addr,
  input  logic [7:0]                      write_byte,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [7:0]                      read_byte,
  output logic [pwm16_pkg::LINE_BITS-1:0] pwm_lines
);
  import pwm16_pkg::*;

  // Input register
  logic       s_valid;
  cmd_t       s_cmd;
  logic [7:0] s_addr;
  logic [7:0] s_byte;
  logic       adv;

  // Device state
  logic [7:0]            mode_reg;
  logic [7:0]            prescale_reg;
  logic [7:0]            divider_count;
  logic [COUNT_BITS-1:0] pwm_count;
  logic [7:0]            mode_next;
  logic [7:0]            prescale_next;
  logic [7:0]            divider_next;
  logic [COUNT_BITS-1:0] pwm_count_next;

  // Address decode
  logic [7:0]               chan_off;
  logic [7:0]               all_off;
  logic                     chan_hit;
  logic                     all_hit;
  logic [CHAN_IDX_BITS-1:0] chan_idx;
  logic [1:0]               byte_sel;
  logic                     do_write;
  logic                     do_tick;

  chan_wr_t    chan_wr   [CHANNELS];
  chan_bytes_t chan_regs [CHANNELS];
  logic [CHANNELS-1:0]  levels;
  logic [LINE_BITS-1:0] lines_next;
  logic [7:0]           rd_byte;

  assign adv      = s_valid && (!out_valid || out_ready);
  assign in_ready = !s_valid || adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      s_valid <= 1'b0;
    end else if (in_ready) begin
      s_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s_cmd  <= cmd;
      s_addr <= reg_addr;
      s_byte <= write_byte;
    end
  end

  assign chan_off = s_addr - CHAN_BASE;
  assign all_off  = s_addr - ALL_BASE;
  assign chan_hit = (s_addr >= CHAN_BASE) && (s_addr < CHAN_LIMIT);
  assign all_hit  = (s_addr >= ALL_BASE) && (s_addr <= ALL_LAST);
  assign chan_idx = chan_off[2 +: CHAN_IDX_BITS];
  assign byte_sel = chan_off[1:0];
  assign do_write = adv && (s_cmd == CMD_WRITE);
  assign do_tick  = adv && (s_cmd == CMD_TICK);

  // Mode and prescale writes; prescale is locked while the device is awake.
  always_comb begin
    mode_next     = mode_reg;
    prescale_next = prescale_reg;
    if (do_write && (s_addr == MODE_ADDR)) begin
      mode_next              = s_byte;
      mode_next[RESTART_BIT] = 1'b0;
    end
    if (do_write && (s_addr == PRESCALE_ADDR) && mode_reg[SLEEP_BIT]) begin
      prescale_next = (s_byte < PRESCALE_MIN) ? PRESCALE_MIN : s_byte;
    end
  end

  always_comb begin
    divider_next   = divider_count;
    pwm_count_next = pwm_count;
    if (do_tick && !mode_reg[SLEEP_BIT]) begin
      if (divider_count >= prescale_reg) begin
        divider_next   = '0;
        pwm_count_next = pwm_count + 1'b1;
      end else begin
        divider_next = divider_count + 8'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode_reg      <= MODE_RESET;
      prescale_reg  <= PRESCALE_RESET;
      divider_count <= '0;
      pwm_count     <= '0;
    end else begin
      mode_reg      <= mode_next;
      prescale_reg  <= prescale_next;
      divider_count <= divider_next;
      pwm_count     <= pwm_count_next;
    end
  end

  for (genvar n = 0; n < CHANNELS; n++) begin : g_chan
    always_comb begin
      for (int i = 0; i < 4; i++) begin
        chan_wr[n].we[i] = do_write &&
            ((chan_hit && (chan_idx == CHAN_IDX_BITS'(n)) && (byte_sel == 2'(i))) ||
             (all_hit && (all_off[1:0] == 2'(i))));
      end
      chan_wr[n].wdata = s_byte;
    end

    pwm16_channel u_chan (
      .clk        (clk),
      .rst        (rst),
      .wr         (chan_wr[n]),
      .count_next (pwm_count_next),
      .regs       (chan_regs[n]),
      .level_next (levels[n])
    );
  end

  // A read never changes state, so the current registers are what it sees.
  always_comb begin
    rd_byte = '0;
    if (s_cmd == CMD_READ) begin
      if (s_addr == MODE_ADDR) begin
        rd_byte = mode_reg;
      end else if (chan_hit) begin
        rd_byte = chan_regs[chan_idx][byte_sel];
      end else if (s_addr == PRESCALE_ADDR) begin
        rd_byte = prescale_reg;
      end
    end
  end

  always_comb begin
    lines_next = '0;
    if (!mode_next[SLEEP_BIT]) begin
      lines_next[CHANNELS-1:0] = levels;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      read_byte <= rd_byte;
      pwm_lines <= lines_next;
    end
  end

endmodule

FILE: rtl/pwm16_checker.sv
// Port-level checks for the PWM register block, bound to its top level.
`timescale 1ns / 1ps

module pwm16_assertions (
  input logic                            clk,
  input logic                            rst,
  input logic                            in_valid,
  input logic                            in_ready,
  input logic                            out_valid,
  input logic                            out_ready,
  input logic [7:0]                      read_byte,
  input logic [pwm16_pkg::LINE_BITS-1:0] pwm_lines
);

  // No result word may appear straight out of reset.
  a_reset_empty : assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result word presented just after reset");

  // With the result register empty, the input side must never stall.
  a_ready_when_empty : assert property (@(posedge clk) disable iff (rst)
      !out_valid |-> in_ready)
    else $error("input stalled while no result was pending");

  // A word taken while the output stalls fills the input register; with the
  // stall still present the input must then close.
  a_fill_then_stall : assert property (@(posedge clk) disable iff (rst)
      (out_valid && !out_ready && in_valid && in_ready) |=> (out_ready || !in_ready))
    else $error("more than two words held while the output stalled");

  // A stalled result word holds its contents.
  a_out_hold : assert property (@(posedge clk) disable iff (rst)
      (out_valid && !out_ready) |=>
        (out_valid && $stable(read_byte) && $stable(pwm_lines)))
    else $error("stalled result word changed or vanished");

endmodule

bind sixteen_channel_pwm_register_block_unit pwm16_assertions u_pwm16_assertions (.*);

FILE: verif/pwm16_checker.sv
// Checker for the PWM register block: mirrors the registers and compares every result word.
`timescale 1ns / 1ps

module pwm16_checker
  import pwm16_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  input  logic                 in_ready,
  input  cmd_t                 cmd,
  input  logic [7:0]           reg_addr,
  input  logic [7:0]           write_byte,
  input  logic                 out_valid,
  input  logic                 out_ready,
  input  logic [7:0]           read_byte,
  input  logic [LINE_BITS-1:0] pwm_lines,
  output int                   fail_count,
  output int                   pending_words
);

  typedef struct packed {
    logic [7:0]           rd;
    logic [LINE_BITS-1:0] lines;
  } word_outcome_t;

  // Mirror of the device state.
  logic [7:0]            mode_q;
  logic [7:0]            prescale_q;
  logic [7:0]            divider_q;
  logic [COUNT_BITS-1:0] count_q;
  logic [7:0]            chan_q [4*CHANNELS];

  word_outcome_t awaited_outcomes[$];
  word_outcome_t seen_exp;
  word_outcome_t new_exp;

  function automatic logic channel_level(int n);
    logic [7:0]  on_hi;
    logic [7:0]  off_hi;
    logic [11:0] on_cnt;
    logic [11:0] off_cnt;
    on_hi   = chan_q[4*n + ON_H];
    off_hi  = chan_q[4*n + OFF_H];
    on_cnt  = {on_hi[3:0], chan_q[4*n + ON_L]};
    off_cnt = {off_hi[3:0], chan_q[4*n + OFF_L]};
    // Full-off wins over full-on.
    if (off_hi[FULL_BIT]) return 1'b0;
    if (on_hi[FULL_BIT]) return 1'b1;
    if (on_cnt < off_cnt) return (count_q >= on_cnt) && (count_q < off_cnt);
    if (on_cnt > off_cnt) return (count_q >= on_cnt) || (count_q < off_cnt);
    return 1'b0;
  endfunction

  function automatic logic [LINE_BITS-1:0] line_levels();
    logic [LINE_BITS-1:0] v;
    v = '0;
    if (!mode_q[SLEEP_BIT]) begin
      for (int n = 0; n < CHANNELS; n++) v[n] = channel_level(n);
    end
    return v;
  endfunction

  task automatic clear_device();
    mode_q     = MODE_RESET;
    prescale_q = PRESCALE_RESET;
    divider_q  = '0;
    count_q    = '0;
    for (int i = 0; i < 4*CHANNELS; i++) chan_q[i] = '0;
  endtask

  // Applies one word to the mirror and returns the result word it should produce.
  task automatic word_outcome(input cmd_t c, input logic [7:0] a, input logic [7:0] b,
                              output word_outcome_t r);
    logic [7:0] rd;
    rd = '0;
    case (c)
      CMD_WRITE: begin
        if (a == MODE_ADDR) begin
          mode_q = b;
          mode_q[RESTART_BIT] = 1'b0;
        end else if (a >= CHAN_BASE && a < CHAN_LIMIT) begin
          chan_q[int'(a - CHAN_BASE)] = b;
        end else if (a >= ALL_BASE && a <= ALL_LAST) begin
          for (int n = 0; n < CHANNELS; n++) chan_q[4*n + int'(a - ALL_BASE)] = b;
        end else if (a == PRESCALE_ADDR) begin
          // Prescale only takes a new value while the device sleeps.
          if (mode_q[SLEEP_BIT]) prescale_q = (b < PRESCALE_MIN) ? PRESCALE_MIN : b;
        end
      end
      CMD_READ: begin
        if (a == MODE_ADDR) rd = mode_q;
        else if (a >= CHAN_BASE && a < CHAN_LIMIT) rd = chan_q[int'(a - CHAN_BASE)];
        else if (a == PRESCALE_ADDR) rd = prescale_q;
      end
      CMD_TICK: begin
        if (!mode_q[SLEEP_BIT]) begin
          if (divider_q >= prescale_q) begin
            divider_q = '0;
            count_q   = count_q + 1'b1;
          end else begin
            divider_q = divider_q + 8'd1;
          end
        end
      end
      default: ;
    endcase
    r.rd    = rd;
    r.lines = line_levels();
  endtask

  always @(posedge clk) begin
    if (rst) begin
      clear_device();
      awaited_outcomes.delete();
      fail_count = 0;
    end else begin
      // The result leaving now always belongs to an older word than one entering now.
      if (out_valid && out_ready) begin
        if (awaited_outcomes.size() == 0) begin
          $error("result word with none expected: read_byte %02h, pwm_lines %04h",
                 read_byte, pwm_lines);
          fail_count++;
        end else begin
          seen_exp = awaited_outcomes.pop_front();
          if (read_byte !== seen_exp.rd) begin
            $error("read_byte: expected %02h, got %02h", seen_exp.rd, read_byte);
            fail_count++;
          end
          if (pwm_lines !== seen_exp.lines) begin
            $error("pwm_lines: expected %04h, got %04h", seen_exp.lines, pwm_lines);
            fail_count++;
          end
        end
      end
      if (in_valid && in_ready) begin
        word_outcome(cmd, reg_addr, write_byte, new_exp);
        awaited_outcomes.push_back(new_exp);
      end
    end
    pending_words = awaited_outcomes.size();
  end

endmodule

FILE: verif/tb.sv
// Top of the PWM register block testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module tb;
  import pwm16_pkg::*;

  localparam cmd_t CMD_SPARE    = 2'd3;
  localparam int   WORD_TOTAL   = 1550;
  localparam int   CALM_WORDS   = 200;
  localparam int   STALL_LIMIT  = 500;
  localparam int   DRAIN_CYCLES = 8;

  logic                 clk;
  logic                 rst;
  logic                 in_valid;
  logic                 in_ready;
  cmd_t                 cmd;
  logic [7:0]           reg_addr;
  logic [7:0]           write_byte;
  logic                 out_valid;
  logic                 out_ready;
  logic [7:0]           read_byte;
  logic [LINE_BITS-1:0] pwm_lines;

  int fail_count;
  int pending_words;
  int words_sent;
  int idle_cycles;
  bit calm;
  bit paused_midway;

  sixteen_channel_pwm_register_block_unit dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .cmd        (cmd),
    .reg_addr   (reg_addr),
    .write_byte (write_byte),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .read_byte  (read_byte),
    .pwm_lines  (pwm_lines)
  );

  pwm16_checker checker_i (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .cmd           (cmd),
    .reg_addr      (reg_addr),
    .write_byte    (write_byte),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .read_byte     (read_byte),
    .pwm_lines     (pwm_lines),
    .fail_count    (fail_count),
    .pending_words (pending_words)
  );

  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Ends the run if neither channel moves a word for too long.
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("Verification failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Receiver stalls in short bursts, never once the run has gone calm.
  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (!calm && !rst && $urandom_range(0, 7) == 0) begin
        out_ready = 1'b0;
        repeat ($urandom_range(0, 4)) @(negedge clk);
      end else begin
        out_ready = 1'b1;
      end
    end
  end

  task automatic send_word(input cmd_t c, input logic [7:0] a, input logic [7:0] d);
    if (!calm && $urandom_range(0, 5) == 0) begin
      @(negedge clk);
      in_valid = 1'b0;
      repeat ($urandom_range(0, 4)) @(negedge clk);
    end
    @(negedge clk);
    in_valid   = 1'b1;
    cmd        = c;
    reg_addr   = a;
    write_byte = d;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    words_sent++;
  endtask

  task automatic write_reg(input logic [7:0] a, input logic [7:0] d);
    send_word(CMD_WRITE, a, d);
  endtask

  task automatic read_reg(input logic [7:0] a);
    send_word(CMD_READ, a, 8'($urandom));
  endtask

  task automatic tick_run(input int n);
    repeat (n) send_word(CMD_TICK, 8'($urandom), 8'($urandom));
  endtask

  // Holds the sender off until every outstanding result word has come back.
  task automatic wait_quiet();
    @(negedge clk);
    in_valid = 1'b0;
    while (pending_words != 0) @(negedge clk);
  endtask

  // Counts mostly stay low so that the counter actually crosses them.
  function automatic logic [11:0] pick_count();
    if ($urandom_range(0, 3) != 0) return 12'($urandom_range(0, 255));
    return 12'($urandom_range(0, 4095));
  endfunction

  function automatic logic [7:0] pick_mapped_addr();
    case ($urandom_range(0, 5))
      0:       return MODE_ADDR;
      1:       return PRESCALE_ADDR;
      2:       return 8'(ALL_BASE + $urandom_range(0, 3));
      default: return 8'(CHAN_BASE + $urandom_range(0, 4*CHANNELS - 1));
    endcase
  endfunction

  task automatic setup_channel(input logic [7:0] base);
    logic [11:0] on_cnt;
    logic [11:0] off_cnt;
    on_cnt  = pick_count();
    off_cnt = pick_count();
    write_reg(8'(base + ON_L), on_cnt[7:0]);
    write_reg(8'(base + ON_H), {3'($urandom), $urandom_range(0, 9) == 0, on_cnt[11:8]});
    write_reg(8'(base + OFF_L), off_cnt[7:0]);
    write_reg(8'(base + OFF_H), {3'($urandom), $urandom_range(0, 9) == 0, off_cnt[11:8]});
  endtask

  initial begin
    logic [7:0] mode_bits;
    rst           = 1'b1;
    in_valid      = 1'b0;
    cmd           = CMD_TICK;
    reg_addr      = '0;
    write_byte    = '0;
    words_sent    = 0;
    calm          = 1'b0;
    paused_midway = 1'b0;
    repeat (2) @(negedge clk);
    rst = 1'b0;

    // Directed words: reset values, prescale floor and sleep lock, restart bit,
    // reserved bits, broadcast group, last channel, unmapped space, spare command.
    read_reg(MODE_ADDR);
    read_reg(PRESCALE_ADDR);
    write_reg(PRESCALE_ADDR, 8'h00);
    read_reg(PRESCALE_ADDR);
    write_reg(PRESCALE_ADDR, 8'hFF);
    read_reg(PRESCALE_ADDR);
    write_reg(MODE_ADDR, 8'hFF);
    read_reg(MODE_ADDR);
    write_reg(8'(ALL_BASE + ON_H), 8'hEF);
    read_reg(8'(CHAN_BASE + ON_H));
    read_reg(8'(ALL_BASE + ON_H));
    write_reg(8'(CHAN_LIMIT - 1), 8'hFF);
    read_reg(8'(CHAN_LIMIT - 1));
    write_reg(CHAN_LIMIT, 8'hFF);
    read_reg(CHAN_LIMIT);
    read_reg(8'hFF);
    send_word(CMD_SPARE, PRESCALE_ADDR, 8'h00);
    write_reg(PRESCALE_ADDR, 8'h02);
    write_reg(MODE_ADDR, 8'h00);
    write_reg(PRESCALE_ADDR, 8'h80);
    read_reg(PRESCALE_ADDR);
    write_reg(8'(CHAN_BASE + 4 + ON_H), 8'h10);
    tick_run(4);
    wait_quiet();

    // Random part: mostly well-formed programming sequences with ticks between them.
    while (words_sent < WORD_TOTAL) begin
      calm = (words_sent > WORD_TOTAL - CALM_WORDS);
      if (!paused_midway && words_sent > WORD_TOTAL / 2) begin
        paused_midway = 1'b1;
        wait_quiet();
      end
      case ($urandom_range(0, 99)) inside
        [0:24]: begin
          setup_channel(8'(CHAN_BASE + 4 * $urandom_range(0, CHANNELS - 1)));
          if ($urandom_range(0, 1) == 0) read_reg(pick_mapped_addr());
        end
        [25:54]: tick_run($urandom_range(4, 40));
        [55:64]: repeat ($urandom_range(1, 4)) read_reg(pick_mapped_addr());
        [65:71]: begin
          // Sleep, reprogram the prescaler, then wake up again.
          mode_bits = 8'($urandom);
          mode_bits[SLEEP_BIT] = 1'b1;
          write_reg(MODE_ADDR, mode_bits);
          if ($urandom_range(0, 4) != 0) write_reg(PRESCALE_ADDR, 8'($urandom_range(0, 6)));
          else write_reg(PRESCALE_ADDR, 8'($urandom));
          read_reg(PRESCALE_ADDR);
          if ($urandom_range(0, 1) == 0) tick_run($urandom_range(1, 4));
          mode_bits = 8'($urandom);
          mode_bits[SLEEP_BIT] = 1'b0;
          write_reg(MODE_ADDR, mode_bits);
          read_reg(MODE_ADDR);
          write_reg(PRESCALE_ADDR, 8'($urandom));
        end
        [72:79]: begin
          setup_channel(ALL_BASE);
          read_reg(8'(ALL_BASE + $urandom_range(0, 3)));
        end
        default: begin
          repeat ($urandom_range(1, 6))
            send_word(cmd_t'($urandom_range(0, 3)), 8'($urandom), 8'($urandom));
        end
      endcase
    end

    @(negedge clk);
    in_valid = 1'b0;
    while (pending_words != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (fail_count == 0 && pending_words == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
